### hdl/dtod_pkg.sv
// Shared types and constants for the delay trend overuse detector.
// Holds fixed-point limits, register indexes, FSM states and the control structs.
// No dependencies; every other file in this folder refers to it by scoped names.
package dtod_pkg;

	// Cap on the sample count that scales the trend.
	localparam int unsigned SAMPLE_CAP = 60;
	localparam logic [9:0]  SAMPLE_CAP_N = 10'(SAMPLE_CAP);

	// Threshold limits and margins, unsigned Q16.16.
	localparam logic [25:0] THR_RESET    = 26'd819200;
	localparam logic [25:0] THR_MIN      = 26'd393216;
	localparam logic [25:0] THR_MAX      = 26'd39321600;
	localparam logic [25:0] SPIKE_MARGIN = 26'd983040;

	// Elapsed time cap in ms and saturation values.
	localparam logic [6:0]  DT_CAP     = 7'd100;
	localparam logic [19:0] OTIME_MAX  = 20'hFFFFF;
	localparam logic [30:0] SCALED_MAX = 31'h7FFFFFFF;
	localparam logic [7:0]  COUNT_MAX  = 8'hFF;

	// Configuration register indexes.
	localparam logic [2:0] REG_TREND_GAIN  = 3'd0;
	localparam logic [2:0] REG_RATE_UP     = 3'd1;
	localparam logic [2:0] REG_RATE_DOWN   = 3'd2;
	localparam logic [2:0] REG_OTIME_LIMIT = 3'd3;
	localparam logic [2:0] REG_COUNT_LIMIT = 3'd4;

	// Configuration reset values.
	localparam logic [15:0] TREND_GAIN_RST  = 16'd1024;
	localparam logic [15:0] RATE_UP_RST     = 16'd9122;
	localparam logic [15:0] RATE_DOWN_RST   = 16'd40894;
	localparam logic [15:0] OTIME_LIMIT_RST = 16'd160;
	localparam logic [7:0]  COUNT_LIMIT_RST = 8'd1;

	// Link usage classification.
	typedef enum logic [1:0] {
		USAGE_NORMAL = 2'd0,
		USAGE_UNDER  = 2'd1,
		USAGE_OVER   = 2'd2
	} usage_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_GAIN,
		ST_MUL_COUNT,
		ST_CLASSIFY,
		ST_MUL_RATE,
		ST_MUL_TIME,
		ST_APPLY,
		ST_WRITE
	} state_t;

	// Operand selection for the shared multiplier.
	typedef enum logic [1:0] {
		MUL_OP_GAIN,
		MUL_OP_COUNT,
		MUL_OP_RATE,
		MUL_OP_TIME
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_in;
		logic    mul_en;
		mul_op_t mul_op;
		logic    classify;
		logic    apply;
		logic    write_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic few_samples;
		logic spike;
		logic out_free;
	} ctrl_status_t;

endpackage

### hdl/dtod_ctrl.sv
// Controller state machine of the delay trend overuse detector.
// Sequences the shared multiplier, classification, threshold update and output write.
// Depends on dtod_pkg.
module dtod_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dtod_pkg::ctrl_status_t status,
	output dtod_pkg::ctrl_cmd_t   cmd
);

	dtod_pkg::state_t state_q, state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtod_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dtod_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = status.few_samples ? dtod_pkg::ST_WRITE : dtod_pkg::ST_MUL_GAIN;
				end
			end
			dtod_pkg::ST_MUL_GAIN:  state_next = dtod_pkg::ST_MUL_COUNT;
			dtod_pkg::ST_MUL_COUNT: state_next = dtod_pkg::ST_CLASSIFY;
			dtod_pkg::ST_CLASSIFY: begin
				state_next = status.spike ? dtod_pkg::ST_WRITE : dtod_pkg::ST_MUL_RATE;
			end
			dtod_pkg::ST_MUL_RATE:  state_next = dtod_pkg::ST_MUL_TIME;
			dtod_pkg::ST_MUL_TIME:  state_next = dtod_pkg::ST_APPLY;
			dtod_pkg::ST_APPLY:     state_next = dtod_pkg::ST_WRITE;
			dtod_pkg::ST_WRITE: begin
				if (status.out_free) begin
					state_next = dtod_pkg::ST_IDLE;
				end
			end
			default: state_next = dtod_pkg::ST_IDLE;
		endcase
	end

	// Command outputs decoded from the current state.
	always_comb begin
		cmd          = '0;
		cmd.mul_op   = dtod_pkg::MUL_OP_GAIN;
		in_ready     = 1'b0;
		unique case (state_q)
			dtod_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			dtod_pkg::ST_MUL_GAIN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dtod_pkg::MUL_OP_GAIN;
			end
			dtod_pkg::ST_MUL_COUNT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dtod_pkg::MUL_OP_COUNT;
			end
			dtod_pkg::ST_CLASSIFY: begin
				cmd.classify = 1'b1;
			end
			dtod_pkg::ST_MUL_RATE: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dtod_pkg::MUL_OP_RATE;
			end
			dtod_pkg::ST_MUL_TIME: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = dtod_pkg::MUL_OP_TIME;
			end
			dtod_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			dtod_pkg::ST_WRITE: begin
				cmd.write_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/dtod_datapath.sv
// Datapath of the delay trend overuse detector: configuration registers, detector
// state, one shared 48x16 multiplier, classification, threshold adaptation, output register.
// Depends on dtod_pkg; driven by dtod_ctrl through the command struct.
module dtod_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dtod_pkg::ctrl_cmd_t   cmd,
	output dtod_pkg::ctrl_status_t status,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  trend_present,
	input  logic signed [31:0]    trend,
	input  logic [15:0]           departure_gap,
	input  logic [9:0]            sample_count,
	input  logic [31:0]           now_ms,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [1:0]            usage,
	output logic [25:0]           threshold_now
);

	// Configuration registers.
	logic [15:0] gain_q, rate_up_q, rate_down_q, otime_limit_q;
	logic [7:0]  count_limit_q;

	// Detector state.
	logic [25:0]        thr_q;
	logic signed [31:0] prior_trend_q;
	logic               update_seen_q;
	logic [31:0]        update_time_q;
	logic               running_q;
	logic [19:0]        otime_q;
	logic [7:0]         count_q;
	dtod_pkg::usage_t   usage_state_q;

	// Per-word working registers.
	logic               skip_q;
	logic signed [31:0] t_q;
	logic [9:0]         n_q;
	logic [15:0]        gap_q;
	logic [31:0]        now_q;
	logic [63:0]        prod_q;
	logic [15:0]        k_q;
	logic [6:0]         dt_q;
	logic               diff_neg_q;
	logic [25:0]        absdiff_q;

	// Output register.
	logic               out_valid_q;
	dtod_pkg::usage_t   usage_q;
	logic [25:0]        thr_out_q;

	// Combinational terms.
	logic [31:0] abs_t;
	logic [47:0] mul_a;
	logic [15:0] mul_b;
	logic [63:0] prod_next;
	logic [30:0] mag;
	logic [30:0] thr_ext;
	logic [30:0] spike_level;
	logic        mag_gt_thr, mag_lt_thr;
	logic        over, under;
	logic [30:0] diff_full;
	logic [31:0] elapsed;
	logic [6:0]  dt;
	logic [20:0] otime_sum;
	logic [19:0] otime_new;
	logic [7:0]  count_new;
	logic        trigger;
	logic [28:0] step;
	logic signed [30:0] thr_cand;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= dtod_pkg::TREND_GAIN_RST;
			rate_up_q     <= dtod_pkg::RATE_UP_RST;
			rate_down_q   <= dtod_pkg::RATE_DOWN_RST;
			otime_limit_q <= dtod_pkg::OTIME_LIMIT_RST;
			count_limit_q <= dtod_pkg::COUNT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtod_pkg::REG_TREND_GAIN:  gain_q        <= cfg_data;
				dtod_pkg::REG_RATE_UP:     rate_up_q     <= cfg_data;
				dtod_pkg::REG_RATE_DOWN:   rate_down_q   <= cfg_data;
				dtod_pkg::REG_OTIME_LIMIT: otime_limit_q <= cfg_data;
				dtod_pkg::REG_COUNT_LIMIT: count_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Capture the input word; the trend falls back to the prior one when absent.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			skip_q <= status.few_samples;
			t_q    <= trend_present ? trend : prior_trend_q;
			n_q    <= (sample_count < dtod_pkg::SAMPLE_CAP_N) ? sample_count
			                                                  : dtod_pkg::SAMPLE_CAP_N;
			gap_q  <= departure_gap;
			now_q  <= now_ms;
		end
	end

	// Shared multiplier with operand selection per step.
	assign abs_t = t_q[31] ? 32'(-t_q) : 32'(t_q);

	always_comb begin
		unique case (cmd.mul_op)
			dtod_pkg::MUL_OP_GAIN: begin
				mul_a = {16'd0, abs_t};
				mul_b = gain_q;
			end
			dtod_pkg::MUL_OP_COUNT: begin
				mul_a = prod_q[47:0];
				mul_b = {6'd0, n_q};
			end
			dtod_pkg::MUL_OP_RATE: begin
				mul_a = {22'd0, absdiff_q};
				mul_b = k_q;
			end
			dtod_pkg::MUL_OP_TIME: begin
				mul_a = prod_q[47:0];
				mul_b = {9'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_next = {16'd0, mul_a} * {48'd0, mul_b};

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_next;
		end
	end

	// Scaled trend magnitude in Q16.16, saturated to 31 bits.
	assign mag = (|prod_q[63:47]) ? dtod_pkg::SCALED_MAX : prod_q[46:16];

	// Compare against the threshold and the spike level.
	assign thr_ext     = {5'd0, thr_q};
	assign spike_level = thr_ext + {5'd0, dtod_pkg::SPIKE_MARGIN};
	assign mag_gt_thr  = mag > thr_ext;
	assign mag_lt_thr  = mag < thr_ext;
	assign over        = !t_q[31] && mag_gt_thr;
	assign under       = t_q[31] && mag_gt_thr;
	assign diff_full   = mag_lt_thr ? (thr_ext - mag) : (mag - thr_ext);

	// Elapsed time since the last update, capped; zero before the first update.
	assign elapsed = now_q - update_time_q;
	always_comb begin
		if (!update_seen_q) begin
			dt = '0;
		end else if (elapsed > {25'd0, dtod_pkg::DT_CAP}) begin
			dt = dtod_pkg::DT_CAP;
		end else begin
			dt = elapsed[6:0];
		end
	end

	// Over-threshold timer and counter.
	assign otime_sum = {1'b0, otime_q} + {5'd0, gap_q};
	always_comb begin
		if (!running_q) begin
			otime_new = {5'd0, gap_q[15:1]};
		end else if (otime_sum[20]) begin
			otime_new = dtod_pkg::OTIME_MAX;
		end else begin
			otime_new = otime_sum[19:0];
		end
	end
	assign count_new = (count_q != dtod_pkg::COUNT_MAX) ? count_q + 8'd1 : count_q;
	assign trigger   = (otime_new > {4'd0, otime_limit_q}) && (count_new > count_limit_q)
	                   && (t_q >= prior_trend_q);

	// Threshold step and clamp.
	assign step     = prod_q[48:20];
	assign thr_cand = diff_neg_q ? ($signed(thr_ext) - $signed({2'd0, step}))
	                             : ($signed(thr_ext) + $signed({2'd0, step}));

	// Detector state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= dtod_pkg::THR_RESET;
			prior_trend_q <= '0;
			update_seen_q <= 1'b0;
			update_time_q <= '0;
			running_q     <= 1'b0;
			otime_q       <= '0;
			count_q       <= '0;
			usage_state_q <= dtod_pkg::USAGE_NORMAL;
		end else if (cmd.classify) begin
			if (over) begin
				running_q <= 1'b1;
				if (trigger) begin
					otime_q       <= '0;
					count_q       <= '0;
					usage_state_q <= dtod_pkg::USAGE_OVER;
				end else begin
					otime_q <= otime_new;
					count_q <= count_new;
				end
			end else begin
				running_q     <= 1'b0;
				otime_q       <= '0;
				count_q       <= '0;
				usage_state_q <= under ? dtod_pkg::USAGE_UNDER : dtod_pkg::USAGE_NORMAL;
			end
			prior_trend_q <= t_q;
			update_seen_q <= 1'b1;
			update_time_q <= now_q;
		end else if (cmd.apply) begin
			if (thr_cand < $signed({5'd0, dtod_pkg::THR_MIN})) begin
				thr_q <= dtod_pkg::THR_MIN;
			end else if (thr_cand > $signed({5'd0, dtod_pkg::THR_MAX})) begin
				thr_q <= dtod_pkg::THR_MAX;
			end else begin
				thr_q <= thr_cand[25:0];
			end
		end
	end

	// Adaptation operands latched during classification.
	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			k_q        <= mag_lt_thr ? rate_down_q : rate_up_q;
			dt_q       <= dt;
			diff_neg_q <= mag_lt_thr;
			absdiff_q  <= diff_full[25:0];
		end
	end

	// Output register decouples the receiver from the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			usage_q   <= skip_q ? dtod_pkg::USAGE_NORMAL : usage_state_q;
			thr_out_q <= thr_q;
		end
	end

	// Status back to the controller.
	assign status.few_samples = sample_count < 10'd2;
	assign status.spike       = mag > spike_level;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign usage         = usage_q;
	assign threshold_now = thr_out_q;

endmodule

### hdl/delay_trend_overuse_detector_top.sv
// Top level of the delay trend overuse detector.
// Instantiates dtod_ctrl and dtod_datapath; depends on dtod_pkg.
//
// Usage: one trend report word enters on the input channel (in_valid/in_ready) and
// one classification word leaves on the output channel (out_valid/out_ready) with
// the link usage and the threshold after the update. Registers are to be written by
// the user through cfg_we/cfg_index/cfg_data only while no word is in flight; the
// block itself does not enforce this. in_ready rises in the same cycle as out_valid,
// so a new report is accepted only once the last one has been written out. A full
// report makes four passes through the single shared 48x16 multiplier (trend times
// gain, times sample count, rate times difference, times elapsed time) plus the
// classification, threshold update and output write steps. A latency spike skips
// the last two products and the threshold update; a report with fewer than two
// samples goes straight to the output.
// Reset: the threshold returns to 12.5, all timers, counters and the prior trend clear,
// registers take their default values and the output channel empties.
// Stall: the finished word waits in the output register; the next report may be
// accepted and computed meanwhile, but its result is held back until the register frees.
module delay_trend_overuse_detector_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               trend_present,
	input  logic signed [31:0] trend,
	input  logic [15:0]        departure_gap,
	input  logic [9:0]         sample_count,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         usage,
	output logic [25:0]        threshold_now
);

	dtod_pkg::ctrl_cmd_t    cmd;
	dtod_pkg::ctrl_status_t status;

	// Sequencer.
	dtod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and state.
	dtod_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.trend_present (trend_present),
		.trend         (trend),
		.departure_gap (departure_gap),
		.sample_count  (sample_count),
		.now_ms        (now_ms),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.usage         (usage),
		.threshold_now (threshold_now)
	);

endmodule

### hdl/dtod_checker.sv
// Port-level checker for the delay trend overuse detector, bound to the top level.
// Depends on dtod_pkg for the threshold limits and usage codes.
module dtod_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  usage,
	input logic [25:0] threshold_now
);

	// A stalled result word holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(usage) && $stable(threshold_now))
		else $error("output word changed while stalled");

	// The reported threshold always stays inside the clamp range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (threshold_now >= dtod_pkg::THR_MIN) &&
		              (threshold_now <= dtod_pkg::THR_MAX))
		else $error("threshold outside clamp range");

	// Only the three defined usage codes are reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (usage == dtod_pkg::USAGE_NORMAL) || (usage == dtod_pkg::USAGE_UNDER) ||
		              (usage == dtod_pkg::USAGE_OVER))
		else $error("undefined usage code");

	// The block works on one report at a time: busy right after accepting one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a report is in flight");

endmodule

bind delay_trend_overuse_detector_top dtod_checker u_dtod_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.usage         (usage),
	.threshold_now (threshold_now)
);

### verif/tb_delay_trend_overuse_detector_top.sv
// Testbench for delay_trend_overuse_detector_top: reports go in, usage words are predicted
// in step with each accepted report and compared field by field as they come out.
// Depends on dtod_pkg and the detector RTL; needs no other files.
module tb_delay_trend_overuse_detector_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Drain settle time, mismatch print budget and handy Q8.24 trend values.
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTED  = 10;
	localparam logic signed [31:0] TREND_ONE     = 32'sd16777216;
	localparam logic signed [31:0] TREND_QUARTER = 32'sd4194304;
	localparam logic signed [31:0] TREND_HALF    = 32'sd8388608;

	typedef struct {
		dtod_pkg::usage_t usage;
		logic [25:0]      threshold;
	} link_verdict_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               trend_present;
	logic signed [31:0] trend;
	logic [15:0]        departure_gap;
	logic [9:0]         sample_count;
	logic [31:0]        now_ms;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         usage;
	logic [25:0]        threshold_now;

	// Verdicts still owed by the block, oldest first.
	link_verdict_t pending_verdicts[$];
	int            fail_count;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            trend_walk;
	logic [31:0]   wall_clock_ms;

	// Detector state and registers as the testbench expects them to be.
	longint           thr_m;
	longint           prior_trend_m;
	logic             seen_m;
	logic [31:0]      upd_time_m;
	logic             otimer_running_m;
	int unsigned      otime_m;
	logic [7:0]       ocount_m;
	dtod_pkg::usage_t usage_m;
	logic [15:0]      gain_m;
	logic [15:0]      rate_up_m;
	logic [15:0]      rate_down_m;
	logic [15:0]      otime_lim_m;
	logic [7:0]       count_lim_m;

	delay_trend_overuse_detector_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.trend_present (trend_present),
		.trend         (trend),
		.departure_gap (departure_gap),
		.sample_count  (sample_count),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.usage         (usage),
		.threshold_now (threshold_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver stalls at the rate the current test asks for.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic reset_model();
		thr_m            = longint'(dtod_pkg::THR_RESET);
		prior_trend_m    = 0;
		seen_m           = 1'b0;
		upd_time_m       = '0;
		otimer_running_m = 1'b0;
		otime_m          = 0;
		ocount_m         = '0;
		usage_m          = dtod_pkg::USAGE_NORMAL;
		gain_m           = dtod_pkg::TREND_GAIN_RST;
		rate_up_m        = dtod_pkg::RATE_UP_RST;
		rate_down_m      = dtod_pkg::RATE_DOWN_RST;
		otime_lim_m      = dtod_pkg::OTIME_LIMIT_RST;
		count_lim_m      = dtod_pkg::COUNT_LIMIT_RST;
	endtask

	// Classifies one report and moves the threshold, updating the expected state.
	function automatic void classify_link_usage(input logic present,
		input logic signed [31:0] tr, input logic [15:0] gap, input logic [9:0] cnt,
		input logic [31:0] now, output link_verdict_t v);
		longint      t;
		longint      n;
		longint      mag;
		longint      scaled;
		longint      k;
		longint      diff;
		longint      step;
		logic [31:0] dt;

		// Too few samples: report normal and leave everything alone.
		if (cnt < 10'd2) begin
			v.usage     = dtod_pkg::USAGE_NORMAL;
			v.threshold = thr_m[25:0];
			return;
		end

		// Scale the trend by the capped sample count and the gain, saturating the magnitude.
		t   = present ? longint'(tr) : prior_trend_m;
		n   = (cnt < dtod_pkg::SAMPLE_CAP_N) ? longint'(cnt) : longint'(dtod_pkg::SAMPLE_CAP);
		mag = (t < 0) ? -t : t;
		mag = (n * mag * longint'(gain_m)) >> 16;
		if (mag > longint'(dtod_pkg::SCALED_MAX))
			mag = longint'(dtod_pkg::SCALED_MAX);
		scaled = (t < 0) ? -mag : mag;

		// Over-threshold timer and count decide when overuse is declared.
		if (scaled > thr_m) begin
			if (!otimer_running_m) begin
				otimer_running_m = 1'b1;
				otime_m          = gap >> 1;
			end else begin
				otime_m = otime_m + gap;
				if (otime_m > dtod_pkg::OTIME_MAX)
					otime_m = dtod_pkg::OTIME_MAX;
			end
			if (ocount_m < dtod_pkg::COUNT_MAX)
				ocount_m++;
			if (otime_m > otime_lim_m && ocount_m > count_lim_m && t >= prior_trend_m) begin
				otime_m  = 0;
				ocount_m = '0;
				usage_m  = dtod_pkg::USAGE_OVER;
			end
		end else begin
			otimer_running_m = 1'b0;
			otime_m          = 0;
			ocount_m         = '0;
			usage_m          = (scaled < -thr_m) ? dtod_pkg::USAGE_UNDER
			                                     : dtod_pkg::USAGE_NORMAL;
		end
		prior_trend_m = t;

		// Threshold adaptation; a latency spike only refreshes the update time.
		if (!seen_m) begin
			seen_m     = 1'b1;
			upd_time_m = now;
		end
		mag = (scaled < 0) ? -scaled : scaled;
		if (mag > thr_m + longint'(dtod_pkg::SPIKE_MARGIN)) begin
			upd_time_m = now;
		end else begin
			k  = (mag < thr_m) ? longint'(rate_down_m) : longint'(rate_up_m);
			dt = now - upd_time_m;
			if (dt > dtod_pkg::DT_CAP)
				dt = dtod_pkg::DT_CAP;
			diff  = mag - thr_m;
			step  = (k * ((diff < 0) ? -diff : diff) * longint'(dt)) >> 20;
			thr_m = (diff < 0) ? thr_m - step : thr_m + step;
			if (thr_m < longint'(dtod_pkg::THR_MIN))
				thr_m = longint'(dtod_pkg::THR_MIN);
			if (thr_m > longint'(dtod_pkg::THR_MAX))
				thr_m = longint'(dtod_pkg::THR_MAX);
			upd_time_m = now;
		end

		v.usage     = usage_m;
		v.threshold = thr_m[25:0];
	endfunction

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Each output word is checked against the oldest pending verdict.
	always @(posedge clk) begin : check_verdicts
		link_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				note_mismatch($sformatf("unexpected word: usage %0d threshold %0d",
					usage, threshold_now));
			end else begin
				want = pending_verdicts.pop_front();
				if (usage !== want.usage)
					note_mismatch($sformatf("usage expected %0d got %0d",
						want.usage, usage));
				if (threshold_now !== want.threshold)
					note_mismatch($sformatf("threshold_now expected %0d got %0d",
						want.threshold, threshold_now));
			end
		end
	end

	// Sends one report word, idling first at the current rate, and records its verdict.
	task automatic send_report(input logic present, input logic signed [31:0] tr,
		input logic [15:0] gap, input logic [9:0] cnt, input logic [31:0] now);
		link_verdict_t v;
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		trend_present <= present;
		trend         <= tr;
		departure_gap <= gap;
		sample_count  <= cnt;
		now_ms        <= now;
		do
			@(posedge clk);
		while (!in_ready);
		classify_link_usage(present, tr, gap, cnt, now, v);
		pending_verdicts.push_back(v);
	endtask

	// Stops sending and lets every owed word come out before the block is touched.
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			dtod_pkg::REG_TREND_GAIN:  gain_m      = data;
			dtod_pkg::REG_RATE_UP:     rate_up_m   = data;
			dtod_pkg::REG_RATE_DOWN:   rate_down_m = data;
			dtod_pkg::REG_OTIME_LIMIT: otime_lim_m = data;
			dtod_pkg::REG_COUNT_LIMIT: count_lim_m = data[7:0];
			default: ;
		endcase
	endtask

	// Writes all registers; junk rides in the upper byte of the count limit, and one
	// write goes to an index past the register list.
	task automatic set_config(input logic [15:0] gain, input logic [15:0] up,
		input logic [15:0] down, input logic [15:0] tlim, input logic [7:0] clim);
		write_reg(dtod_pkg::REG_TREND_GAIN, gain);
		write_reg(dtod_pkg::REG_RATE_UP, up);
		write_reg(dtod_pkg::REG_RATE_DOWN, down);
		write_reg(dtod_pkg::REG_OTIME_LIMIT, tlim);
		write_reg(dtod_pkg::REG_COUNT_LIMIT, {8'($urandom), clim});
		write_reg(dtod_pkg::REG_COUNT_LIMIT + 3'($urandom_range(1, 3)), 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Mostly a wandering trend with steady time, some fully random reports as noise.
	task automatic random_report();
		logic               present;
		logic signed [31:0] tr;
		logic [15:0]        gap;
		logic [9:0]         cnt;
		logic [31:0]        now;
		if ($urandom_range(99) < 15) begin
			present = 1'($urandom);
			tr      = $urandom;
			gap     = 16'($urandom);
			cnt     = 10'($urandom);
			now     = $urandom;
		end else begin
			if ($urandom_range(29) == 0)
				trend_walk = int'($urandom_range(0, 2 * TREND_ONE)) - TREND_ONE;
			else
				trend_walk += int'($urandom_range(0, TREND_ONE / 8)) - TREND_ONE / 16;
			present = ($urandom_range(9) != 0);
			tr      = trend_walk;
			gap     = 16'($urandom_range(0, 1600));
			cnt     = ($urandom_range(19) == 0) ? 10'($urandom_range(0, 1))
				: 10'($urandom_range(2, 120));
			wall_clock_ms += $urandom_range(0, 120);
			now = wall_clock_ms;
		end
		send_report(present, tr, gap, cnt, now);
	endtask

	// Few samples, extreme trends and counts, wrapping and backward time, spikes.
	task automatic test_sample_count_and_extremes();
		send_report(1'b1, 32'sh7FFFFFFF, 16'hFFFF, 10'd0, 32'd0);
		send_report(1'b1, 32'sh80000000, 16'd0, 10'd1, 32'd7);
		send_report(1'b1, 32'sh7FFFFFFF, 16'hFFFF, 10'd2, 32'd0);
		send_report(1'b0, 32'sh0, 16'hFFFF, 10'h3FF, 32'd5);
		send_report(1'b1, 32'sh80000000, 16'd0, 10'd60, 32'hFFFFFFFF);
		send_report(1'b1, TREND_QUARTER, 16'd16, 10'd10, 32'd10);
		send_report(1'b1, TREND_QUARTER, 16'd16, 10'd59, 32'd3);
		send_report(1'b1, -TREND_QUARTER, 16'd16, 10'd60, 32'd40);
		send_report(1'b0, 32'sh0, 16'd32, 10'd61, 32'd200);
		send_report(1'b1, 32'sh0, 16'd0, 10'd2, 32'd300);
	endtask

	// Overuse declared, then held while the trend falls, then normal and underuse.
	task automatic test_overuse_declaration();
		send_report(1'b1, TREND_HALF, 16'd32, 10'd60, 32'd320);
		send_report(1'b1, TREND_HALF + 1, 16'd160, 10'd60, 32'd340);
		send_report(1'b1, TREND_HALF - TREND_ONE / 16, 16'd320, 10'd60, 32'd360);
		send_report(1'b1, TREND_HALF - TREND_ONE / 8, 16'd320, 10'd60, 32'd380);
		send_report(1'b1, 32'sh0, 16'd16, 10'd30, 32'd400);
		send_report(1'b1, -TREND_HALF, 16'd16, 10'd60, 32'd420);
	endtask

	// Both corners of every register, with the block idle around each write.
	task automatic test_config_extremes();
		wait_for_verdicts();
		set_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 8'hFF);
		repeat (3) random_report();
		wait_for_verdicts();
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0);
		repeat (5) random_report();
	endtask

	// Random reports under two random settings at the given idle rates.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		for (int phase = 0; phase < 2; phase++) begin
			wait_for_verdicts();
			set_config(16'($urandom_range(256, 4096)), 16'($urandom_range(1000, 60000)),
				16'($urandom_range(1000, 60000)), 16'($urandom_range(0, 2000)),
				8'($urandom_range(0, 8)));
			tx_idle_pct = tx_pct;
			rx_idle_pct = rx_pct;
			repeat (n_items / 2) random_report();
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= dtod_pkg::REG_TREND_GAIN;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		trend_present <= 1'b0;
		trend         <= '0;
		departure_gap <= '0;
		sample_count  <= '0;
		now_ms        <= '0;
		fail_count    = 0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		trend_walk    = 0;
		wall_clock_ms = 32'd1000;
		reset_model();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sample_count_and_extremes();
		test_overuse_declaration();
		test_config_extremes();
		test_random_traffic(36, 64, 600);
		test_random_traffic(64, 36, 600);
		test_random_traffic(0, 0, 600);
		wait_for_verdicts();

		if (fail_count == 0 && pending_verdicts.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### delay_trend_overuse_detector_top.f
hdl/dtod_pkg.sv
hdl/dtod_ctrl.sv
hdl/dtod_datapath.sv
hdl/delay_trend_overuse_detector_top.sv
hdl/dtod_checker.sv
verif/tb_delay_trend_overuse_detector_top.sv
